FILE: design/ace_pkg.sv
// Package for the ARP cache engine: operation and status codes, protocol constants,
// the table entry layout and the structs between the top level and the scan unit.
// Depends on nothing.
package ace_pkg;

   // Default table depth.
   localparam int ENTRIES_DEF = 128;

   // Packed stream widths.
   localparam int REQ_W = 224;
   localparam int RSP_W = 136;
   localparam int CSR_IDX_W = 8;

   // Operation codes carried in req_tuser.
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ARP    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Result status codes carried in rsp_tuser.
   localparam logic [2:0] STS_HIT        = 3'd0;
   localparam logic [2:0] STS_MISS       = 3'd1;
   localparam logic [2:0] STS_EXPIRED    = 3'd2;
   localparam logic [2:0] STS_LEARNED    = 3'd3;
   localparam logic [2:0] STS_DROPPED    = 3'd4;
   localparam logic [2:0] STS_NOT_STORED = 3'd5;
   localparam logic [2:0] STS_CLEARED    = 3'd6;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_IP = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFETIME = 8'd1;

   // Register reset values.
   localparam logic [31:0] LOCAL_IP_RST = 32'hC0A8_0164;
   localparam logic [31:0] LIFETIME_RST = 32'd300;

   // ARP packet checks.
   localparam logic [15:0] MIN_PKT_LEN  = 16'd28;
   localparam logic [15:0] HW_TYPE_ETH  = 16'd1;
   localparam logic [15:0] PROTO_IPV4   = 16'h0800;
   localparam logic [7:0]  HW_LEN_MAC   = 8'd6;
   localparam logic [7:0]  PLEN_IPV4    = 8'd4;
   localparam logic [15:0] OPC_REQUEST  = 16'd1;

   // Largest stamp; the oldest-slot search starts from it.
   localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        valid;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] now;
      logic [31:0] lifetime;
   } cmd_type;

   typedef struct packed {
      logic        idle;
      logic        done;
      logic [2:0]  status;
      logic [47:0] found_mac;
   } eng_res_type;

endpackage

FILE: design/ace_scan_unit.sv
// Table memory and the scan sequencer of the ARP cache engine.
// One entry is read and compared per cycle. Depends on ace_pkg.
module ace_scan_unit #(
   parameter int ENTRIES = ace_pkg::ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ace_pkg::cmd_type     cmd,
   output ace_pkg::eng_res_type res
);
   import ace_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   localparam logic [1:0] S_INIT  = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_CLEAR = 2'd3;

   entry_type mem [ENTRIES];

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             issue_ff, issue_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   entry_type        rd_data_ff;

   logic [1:0]       op_ff;
   logic [31:0]      ip_ff, now_ff, life_ff;
   logic [47:0]      mac_ff;

   logic             free_seen_ff, free_seen_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             old_seen_ff, old_seen_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [31:0]      old_time_ff, old_time_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic             match, expired, last, finish, old_upd;
   logic [31:0]      age;
   logic [2:0]       status;
   logic [47:0]      found;
   logic [IDX_W-1:0] slot;

   always_comb begin
      match   = rd_data_ff.valid && (rd_data_ff.ip == ip_ff);
      age     = now_ff - rd_data_ff.stamp;
      expired = age > life_ff;
      last    = rd_idx_ff == LAST;
      old_upd = rd_data_ff.valid && !match && (rd_data_ff.stamp < old_time_ff);

      state_in     = state_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      free_seen_in = free_seen_ff;
      free_idx_in  = free_idx_ff;
      old_seen_in  = old_seen_ff;
      old_idx_in   = old_idx_ff;
      old_time_in  = old_time_ff;
      finish       = 1'b0;
      status       = STS_MISS;
      found        = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;
      slot         = rd_idx_ff;

      case (state_ff)
         S_INIT, S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = S_IDLE;
               finish   = state_ff == S_CLEAR;
               status   = STS_CLEARED;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (cmd.start) begin
               idx_in       = '0;
               free_seen_in = 1'b0;
               old_seen_in  = 1'b0;
               old_time_in  = STAMP_MAX;
               if (cmd.op == OP_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_SCAN;
                  issue_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            // Read side: one address issued per cycle until the last entry.
            rd_vld_in = issue_ff;
            if (issue_ff) begin
               if (idx_ff == LAST) begin
                  issue_in = 1'b0;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            // Compare side: the entry read in the previous cycle.
            if (rd_vld_ff) begin
               if (op_ff == OP_LOOKUP) begin
                  if (match) begin
                     finish = 1'b1;
                     if (expired) begin
                        status        = STS_EXPIRED;
                        wr_en         = 1'b1;
                        wr_addr       = rd_idx_ff;
                        wr_data       = rd_data_ff;
                        wr_data.valid = 1'b0;
                     end else begin
                        status = STS_HIT;
                        found  = rd_data_ff.mac;
                     end
                  end else if (last) begin
                     finish = 1'b1;
                     status = STS_MISS;
                  end
               end else begin
                  if (!rd_data_ff.valid && !free_seen_ff) begin
                     free_seen_in = 1'b1;
                     free_idx_in  = rd_idx_ff;
                  end
                  if (old_upd) begin
                     old_seen_in = 1'b1;
                     old_idx_in  = rd_idx_ff;
                     old_time_in = rd_data_ff.stamp;
                  end
                  if (match || last) begin
                     finish = 1'b1;
                     if (match) begin
                        slot = rd_idx_ff;
                     end else if (free_seen_in) begin
                        slot = free_idx_in;
                     end else begin
                        slot = old_idx_in;
                     end
                     if (match || free_seen_in || old_seen_in) begin
                        status  = STS_LEARNED;
                        wr_en   = 1'b1;
                        wr_addr = slot;
                        wr_data = '{valid: 1'b1, ip: ip_ff, mac: mac_ff, stamp: now_ff};
                     end else begin
                        status = STS_NOT_STORED;
                     end
                  end
               end
            end
            if (finish) begin
               state_in  = S_IDLE;
               issue_in  = 1'b0;
               rd_vld_in = 1'b0;
               idx_in    = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         free_seen_ff <= 1'b0;
         old_seen_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         free_seen_ff <= free_seen_in;
         old_seen_ff  <= old_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= idx_ff;
      free_idx_ff <= free_idx_in;
      old_idx_ff  <= old_idx_in;
      old_time_ff <= old_time_in;
      if (state_ff == S_IDLE && cmd.start) begin
         op_ff   <= cmd.op;
         ip_ff   <= cmd.ip;
         mac_ff  <= cmd.mac;
         now_ff  <= cmd.now;
         life_ff <= cmd.lifetime;
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff];
   end

   assign res.idle      = state_ff == S_IDLE;
   assign res.done      = finish;
   assign res.status    = status;
   assign res.found_mac = found;

endmodule

FILE: design/arp_cache_engine.sv
// Top level of the ARP cache engine: stream ports, configuration registers,
// packet checks and the result register. Depends on ace_pkg and ace_scan_unit.
//
// The engine keeps a table of ENTRIES slots that map IPv4 addresses to MAC
// addresses. Each request word carries an operation in req_tuser: a lookup, a
// received ARP packet to learn from, or a clear of the whole table. The table
// sits in a single-port-read memory and one comparator walks it one entry per
// cycle, so a lookup or a learn ends at the last entry, or earlier when it hits
// early in the table, and the next request can be taken in the same cycle as
// the result word appears if the receiver takes that word. A clear sweeps every
// entry. A packet that fails the length, type or address length checks, and an
// unused operation code, are answered in the next cycle without touching the
// table. After reset the block frees every entry of the table and accepts no
// request meanwhile; configuration writes are taken at any time and should be
// issued only while no request is outstanding. One request is worked on at a
// time; a new request is taken once the result register is free or is being
// emptied.
module arp_cache_engine #(
   parameter int ENTRIES = ace_pkg::ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request words.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // From bit 0: ip_addr[31:0], src_mac[47:0], now[31:0], pkt_length[15:0],
   // hw_type[15:0], ptype[15:0], hw_len[7:0], plen[7:0],
   // arp_opcode[15:0], dest_ip[31:0].
   input  logic [ace_pkg::REQ_W-1:0]      req_tdata,
   // From bit 0: op[1:0].
   input  logic [1:0]                     req_tuser,
   // Result words.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // From bit 0: found_mac[47:0], send_reply, reply_ip[31:0], reply_mac[47:0],
   // then seven zero bits.
   output logic [ace_pkg::RSP_W-1:0]      rsp_tdata,
   // From bit 0: status[2:0].
   output logic [2:0]                     rsp_tuser,
   // Configuration writes.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ace_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);
   import ace_pkg::*;

   // Unpacked request fields.
   logic [1:0]  req_op;
   logic [31:0] req_ip, req_now, req_target;
   logic [47:0] req_mac;
   logic [15:0] req_len, req_hw_type, req_ptype, req_arp_opcode;
   logic [7:0]  req_hw_len, req_plen;

   assign req_op         = req_tuser;
   assign req_ip         = req_tdata[31:0];
   assign req_mac        = req_tdata[79:32];
   assign req_now        = req_tdata[111:80];
   assign req_len        = req_tdata[127:112];
   assign req_hw_type    = req_tdata[143:128];
   assign req_ptype      = req_tdata[159:144];
   assign req_hw_len     = req_tdata[167:160];
   assign req_plen       = req_tdata[175:168];
   assign req_arp_opcode = req_tdata[191:176];
   assign req_target     = req_tdata[223:192];

   // Configuration registers.
   logic [31:0] local_ip_ff, local_ip_in;
   logic [31:0] lifetime_ff, lifetime_in;

   // Control and result registers.
   logic        busy_ff, busy_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [47:0] rsp_found_ff, rsp_found_in;
   logic        rsp_reply_ff, rsp_reply_in;
   logic [31:0] rsp_rip_ff, rsp_rip_in;
   logic [47:0] rsp_rmac_ff, rsp_rmac_in;

   // Reply details held while the table is being scanned.
   logic        pend_reply_ff, pend_reply_in;
   logic [31:0] pend_rip_ff, pend_rip_in;
   logic [47:0] pend_rmac_ff, pend_rmac_in;

   logic        req_accept, pkt_ok, needs_table, reply_now;
   cmd_type     cmd;
   eng_res_type eng;

   ace_scan_unit #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (eng)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff && eng.idle && (!rsp_tvalid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      pkt_ok = (req_len >= MIN_PKT_LEN) && (req_hw_type == HW_TYPE_ETH) &&
               (req_ptype == PROTO_IPV4) && (req_hw_len == HW_LEN_MAC) &&
               (req_plen == PLEN_IPV4);
      // Every operation but a rejected packet or an unused code goes to the table.
      needs_table = (req_op == OP_LOOKUP) || (req_op == OP_CLEAR) ||
                    ((req_op == OP_ARP) && pkt_ok);
      // A reply is owed to any valid request aimed at us, stored or not.
      reply_now = (req_op == OP_ARP) && pkt_ok && (req_arp_opcode == OPC_REQUEST) &&
                  (req_target == local_ip_ff);

      cmd.start    = req_accept && needs_table;
      cmd.op       = req_op;
      cmd.ip       = req_ip;
      cmd.mac      = req_mac;
      cmd.now      = req_now;
      cmd.lifetime = lifetime_ff;
   end

   always_comb begin
      local_ip_in = local_ip_ff;
      lifetime_in = lifetime_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOCAL_IP: local_ip_in = csr_data;
            CSR_LIFETIME: lifetime_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_reply_in  = rsp_reply_ff;
      rsp_rip_in    = rsp_rip_ff;
      rsp_rmac_in   = rsp_rmac_ff;
      pend_reply_in = pend_reply_ff;
      pend_rip_in   = pend_rip_ff;
      pend_rmac_in  = pend_rmac_ff;

      if (req_accept) begin
         if (needs_table) begin
            busy_in       = 1'b1;
            pend_reply_in = reply_now;
            pend_rip_in   = reply_now ? req_ip : 32'd0;
            pend_rmac_in  = reply_now ? req_mac : 48'd0;
         end else begin
            // Rejected packets and unused codes are answered straight away.
            rsp_tvalid_in = 1'b1;
            rsp_status_in = STS_DROPPED;
            rsp_found_in  = '0;
            rsp_reply_in  = 1'b0;
            rsp_rip_in    = '0;
            rsp_rmac_in   = '0;
         end
      end

      if (eng.done) begin
         busy_in       = 1'b0;
         rsp_tvalid_in = 1'b1;
         rsp_status_in = eng.status;
         rsp_found_in  = eng.found_mac;
         rsp_reply_in  = pend_reply_ff;
         rsp_rip_in    = pend_rip_ff;
         rsp_rmac_in   = pend_rmac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff   <= LOCAL_IP_RST;
         lifetime_ff   <= LIFETIME_RST;
         busy_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         local_ip_ff   <= local_ip_in;
         lifetime_ff   <= lifetime_in;
         busy_ff       <= busy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_reply_ff  <= rsp_reply_in;
      rsp_rip_ff    <= rsp_rip_in;
      rsp_rmac_ff   <= rsp_rmac_in;
      pend_reply_ff <= pend_reply_in;
      pend_rip_ff   <= pend_rip_in;
      pend_rmac_ff  <= pend_rmac_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_rmac_ff, rsp_rip_ff, rsp_reply_ff, rsp_found_ff};

   // A request is taken only when the result register can hold its answer.
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("request taken while the result register is occupied");

   // The table reports completion only for a request that is outstanding.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      eng.done |-> busy_ff)
      else $error("table scan finished with no request outstanding");

   // While the table works on a request no new request may be taken.
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready)
      else $error("request taken while the table is busy");

   // Lookups and clears never ask for a reply to be sent.
   a_reply_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_status_ff == STS_HIT || rsp_status_ff == STS_MISS ||
       rsp_status_ff == STS_EXPIRED || rsp_status_ff == STS_CLEARED)) |-> !rsp_reply_ff)
      else $error("reply flagged on a lookup or clear result");

endmodule

FILE: sim/arp_cache_engine_tb.sv
// Self-checking testbench for arp_cache_engine: directed and random request words,
// a cycle-free predictor of the ARP table, and field-by-field checks of every result word.
// Depends on ace_pkg and the arp_cache_engine RTL.
module arp_cache_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ace_pkg::*;

   localparam int SLOTS = ENTRIES_DEF;
   localparam int POOL_SIZE = 160;
   // The receiver's long hold-off, long enough for the engine to back up onto its input.
   localparam int PRESSURE_CYCLES = 400;
   // Slowest quiet stretch in a correct run is the pressure hold-off or the clearing pass
   // after reset plus a full scan; this is several times that.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [15:0] OPC_REPLY = 16'd2;
   // Base of a block of addresses for filling the table; the random address pool is not kept clear of it.
   localparam logic [31:0] FILL_BASE = 32'hC633_6400;

   // Request word fields, highest bits first, so that a cast gives req_tdata directly.
   typedef struct packed {
      logic [31:0] dest_ip;
      logic [15:0] opcode;
      logic [7:0]  plen;
      logic [7:0]  hw_len;
      logic [15:0] ptype;
      logic [15:0] hw_type;
      logic [15:0] pkt_len;
      logic [31:0] now;
      logic [47:0] mac;
      logic [31:0] ip;
   } req_fields_t;

   typedef struct packed {
      logic [1:0]  op;
      req_fields_t f;
   } req_item_t;

   // Result word fields, laid out as rsp_tdata.
   typedef struct packed {
      logic [6:0]  pad;
      logic [47:0] reply_mac;
      logic [31:0] reply_ip;
      logic        send_reply;
      logic [47:0] found_mac;
   } rsp_word_t;

   typedef struct packed {
      logic [2:0] status;
      rsp_word_t  word;
   } answer_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   wire req_fire = req_tvalid && req_tready;
   wire rsp_fire = rsp_tvalid && rsp_tready;
   wire csr_fire = csr_valid && csr_ready;

   // Handshakes seen at the last rising edge, read by the processes that drive at the
   // falling edge.
   logic req_fire_q = 1'b0;
   logic csr_fire_q = 1'b0;

   req_item_t   pending_words[$];
   answer_t     expected_answers[$];
   int          words_issued = 0;
   int          answers_checked = 0;
   int          failures = 0;

   int          send_gap_pct = 0;
   int          recv_gap_pct = 0;
   bit          hold_off_wanted = 1'b0;
   bit          hold_off_done = 1'b0;
   int          hold_off_left = 0;

   // Stimulus state: the running clock in seconds, the own address as last written, and
   // a pool of sender addresses small enough that the table fills and entries are reused.
   logic [31:0] gen_now = '0;
   logic [31:0] gen_local_ip = LOCAL_IP_RST;
   logic [31:0] ip_pool [POOL_SIZE];

   // Predictor's own copy of the table and of the registers.
   bit          slot_valid [SLOTS];
   logic [31:0] slot_ip    [SLOTS];
   logic [47:0] slot_mac   [SLOTS];
   logic [31:0] slot_stamp [SLOTS];
   logic [31:0] model_local_ip = LOCAL_IP_RST;
   logic [31:0] model_lifetime = LIFETIME_RST;

   arp_cache_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the result word of one accepted request and updates the table copy.
   function automatic answer_t cache_predict(input req_item_t w);
      answer_t     a;
      int          i;
      int          hit_i;
      int          free_i;
      int          old_i;
      int          pick;
      logic [31:0] old_stamp;
      logic [31:0] age;
      a = '0;
      a.status = STS_DROPPED;
      case (w.op)
         OP_LOOKUP: begin
            a.status = STS_MISS;
            for (i = 0; i < SLOTS; i++) begin
               if (slot_valid[i] && slot_ip[i] == w.f.ip) begin
                  // The age wraps at 32 bits; only an age beyond the lifetime expires.
                  age = w.f.now - slot_stamp[i];
                  if (age > model_lifetime) begin
                     slot_valid[i] = 1'b0;
                     a.status = STS_EXPIRED;
                  end else begin
                     a.status = STS_HIT;
                     a.word.found_mac = slot_mac[i];
                  end
                  break;
               end
            end
         end
         OP_ARP: begin
            if (w.f.pkt_len < MIN_PKT_LEN || w.f.hw_type != HW_TYPE_ETH ||
                w.f.ptype != PROTO_IPV4 || w.f.hw_len != HW_LEN_MAC ||
                w.f.plen != PLEN_IPV4) begin
               a.status = STS_DROPPED;
            end else begin
               hit_i = -1;
               free_i = -1;
               old_i = -1;
               old_stamp = STAMP_MAX;
               // Plain unsigned stamp compare: a slot stamped at the largest value is
               // never taken as the oldest.
               for (i = 0; i < SLOTS; i++) begin
                  if (!slot_valid[i]) begin
                     if (free_i < 0) free_i = i;
                  end else if (slot_ip[i] == w.f.ip) begin
                     hit_i = i;
                     break;
                  end else if (slot_stamp[i] < old_stamp) begin
                     old_stamp = slot_stamp[i];
                     old_i = i;
                  end
               end
               pick = (hit_i >= 0) ? hit_i : ((free_i >= 0) ? free_i : old_i);
               if (pick < 0) begin
                  a.status = STS_NOT_STORED;
               end else begin
                  slot_valid[pick] = 1'b1;
                  slot_ip[pick] = w.f.ip;
                  slot_mac[pick] = w.f.mac;
                  slot_stamp[pick] = w.f.now;
                  a.status = STS_LEARNED;
               end
               // The reply is owed whether or not the sender found room.
               if (w.f.opcode == OPC_REQUEST && w.f.dest_ip == model_local_ip) begin
                  a.word.send_reply = 1'b1;
                  a.word.reply_ip = w.f.ip;
                  a.word.reply_mac = w.f.mac;
               end
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
            a.status = STS_CLEARED;
         end
         default: a.status = STS_DROPPED;
      endcase
      return a;
   endfunction

   function automatic void compare_field(input string field, input logic [47:0] want,
                                         input logic [47:0] got);
      if (got !== want) begin
         $display("[%0t] %s mismatch: expected %h, got %h", $time, field, want, got);
         failures++;
      end
   endfunction

   function automatic req_fields_t random_fields();
      return req_fields_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom()});
   endfunction

   function automatic logic [31:0] pool_ip();
      return ($urandom_range(0, 7) == 0) ? 32'($urandom())
                                         : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // A well-formed ARP packet; most lengths are random, a quarter the shortest allowed.
   function automatic req_item_t make_arp(input logic [31:0] src_ip,
                                          input logic [47:0] src_mac,
                                          input logic [31:0] stamp,
                                          input logic [15:0] opcode,
                                          input logic [31:0] target);
      req_item_t w;
      w.op = OP_ARP;
      w.f.ip = src_ip;
      w.f.mac = src_mac;
      w.f.now = stamp;
      w.f.pkt_len = ($urandom_range(0, 3) == 0) ? MIN_PKT_LEN
                                                : 16'($urandom_range(MIN_PKT_LEN, 16'hFFFF));
      w.f.hw_type = HW_TYPE_ETH;
      w.f.ptype = PROTO_IPV4;
      w.f.hw_len = HW_LEN_MAC;
      w.f.plen = PLEN_IPV4;
      w.f.opcode = opcode;
      w.f.dest_ip = target;
      return w;
   endfunction

   // Lookups and clears carry random bits in the fields they do not use.
   function automatic req_item_t make_lookup(input logic [31:0] addr, input logic [31:0] stamp);
      req_item_t w;
      w.op = OP_LOOKUP;
      w.f = random_fields();
      w.f.ip = addr;
      w.f.now = stamp;
      return w;
   endfunction

   function automatic req_item_t make_clear();
      req_item_t w;
      w.op = OP_CLEAR;
      w.f = random_fields();
      return w;
   endfunction

   task automatic enqueue(input req_item_t w);
      pending_words.push_back(w);
      words_issued++;
   endtask

   // One random word: mostly lookups and well-formed packets over the address pool, with
   // a few broken packets, unused operation codes and rare clears so that the table fills.
   task automatic enqueue_random_word();
      req_item_t   w;
      int          pick;
      logic [31:0] stamp;
      logic [15:0] opc;
      logic [31:0] tip;
      pick = $urandom_range(0, 19);
      if (pick == 19) gen_now += $urandom();
      else if (pick >= 17) gen_now += $urandom_range(1, 400);
      else if (pick >= 12) gen_now += $urandom_range(1, 8);
      stamp = ($urandom_range(0, 19) == 0) ? 32'($urandom()) : gen_now;
      pick = $urandom_range(0, 999);
      if (pick < 2) begin
         w = make_clear();
      end else if (pick < 25) begin
         w.op = OP_UNUSED;
         w.f = random_fields();
      end else if (pick < 370) begin
         w = make_lookup(pool_ip(), stamp);
      end else begin
         pick = $urandom_range(0, 9);
         opc = (pick < 5) ? OPC_REQUEST : ((pick < 8) ? OPC_REPLY : 16'($urandom()));
         case ($urandom_range(0, 5))
            0, 1, 2: tip = gen_local_ip;
            3:       tip = gen_local_ip ^ (32'd1 << $urandom_range(0, 31));
            default: tip = $urandom();
         endcase
         w = make_arp(pool_ip(), 48'({$urandom(), $urandom()}), stamp, opc, tip);
         pick = $urandom_range(0, 99);
         if (pick >= 95) begin
            w.f = random_fields();
         end else if (pick >= 85) begin
            case ($urandom_range(0, 4))
               0: w.f.pkt_len = 16'($urandom_range(0, MIN_PKT_LEN - 1));
               1: do w.f.hw_type = 16'($urandom()); while (w.f.hw_type == HW_TYPE_ETH);
               2: do w.f.ptype = 16'($urandom()); while (w.f.ptype == PROTO_IPV4);
               3: do w.f.hw_len = 8'($urandom()); while (w.f.hw_len == HW_LEN_MAC);
               default: do w.f.plen = 8'($urandom()); while (w.f.plen == PLEN_IPV4);
            endcase
         end
      end
      enqueue(w);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(negedge clock); while (!csr_fire_q);
      csr_valid <= 1'b0;
   endtask

   // Waits until every issued word has been answered, so that the engine is idle.
   task automatic drain();
      while (answers_checked != words_issued) @(negedge clock);
   endtask

   task automatic start_phase(input logic [31:0] own_ip, input logic [31:0] lifetime,
                              input int sender_gap, input int receiver_gap);
      drain();
      write_csr(CSR_LOCAL_IP, own_ip);
      write_csr(CSR_LIFETIME, lifetime);
      gen_local_ip = own_ip;
      send_gap_pct = sender_gap;
      recv_gap_pct = receiver_gap;
   endtask

   // Sender: offers the next pending word at the falling edge once the previous one has
   // gone, idling at random between words.
   always @(negedge clock) begin : sender
      req_item_t next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire_q) begin
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            next_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_word.f;
            req_tuser <= next_word.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off while the sender keeps offering, so
   // that the engine's result register fills and its input stops taking words.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_tready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_wanted && !hold_off_done) begin
         rsp_tready <= 1'b0;
         hold_off_left <= PRESSURE_CYCLES;
         hold_off_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // Monitor: samples every handshake at the rising edge. Register writes update the
   // predictor's copy, accepted requests are predicted at once, and result words are
   // checked against the oldest prediction.
   always @(posedge clock) begin : monitor
      req_item_t seen;
      answer_t   want;
      rsp_word_t got;
      req_fire_q <= req_fire && !reset;
      csr_fire_q <= csr_fire && !reset;
      if (!reset) begin
         if (csr_fire) begin
            case (csr_index)
               CSR_LOCAL_IP: model_local_ip = csr_data;
               CSR_LIFETIME: model_lifetime = csr_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            seen.op = req_tuser;
            seen.f = req_tdata;
            expected_answers.push_back(cache_predict(seen));
         end
         if (rsp_fire) begin
            if (expected_answers.size() == 0) begin
               $display("[%0t] result word with nothing expected: status %0d, data %h",
                        $time, rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = expected_answers.pop_front();
               got = rsp_tdata;
               compare_field("status", 48'(want.status), 48'(rsp_tuser));
               compare_field("found_mac", want.word.found_mac, got.found_mac);
               compare_field("send_reply", 48'(want.word.send_reply), 48'(got.send_reply));
               compare_field("reply_ip", 48'(want.word.reply_ip), 48'(got.reply_ip));
               compare_field("reply_mac", want.word.reply_mac, got.reply_mac);
               answers_checked++;
            end
         end
      end
   end

   // Ends the run when no word has moved on any channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire || csr_fire) quiet = 0;
         else quiet++;
      end
      $display("[%0t] no word has moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      req_item_t w;
      int        i;
      for (i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // First phase: sender idles a third of the time, receiver about half.
      start_phase(32'h0A00_0001, LIFETIME_RST, 33, 54);

      // Directed words. An empty table misses; a broadcast-address sender with an
      // all-ones MAC is learned and answered; an age equal to the lifetime still hits
      // and one second more expires the entry, which then misses.
      enqueue(make_lookup(32'hFFFF_FFFF, 32'd0));
      w = make_arp(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd0, OPC_REQUEST, gen_local_ip);
      w.f.pkt_len = MIN_PKT_LEN;
      enqueue(w);
      enqueue(make_lookup(32'hFFFF_FFFF, 32'd300));
      enqueue(make_lookup(32'hFFFF_FFFF, 32'd301));
      enqueue(make_lookup(32'hFFFF_FFFF, 32'd301));
      // Address zero stamped at the top of the clock, then re-learned in place with a
      // new MAC; the lookups check the age across the wrap on both sides of the limit.
      w = make_arp(32'd0, 48'd0, STAMP_MAX, OPC_REPLY, gen_local_ip);
      w.f.pkt_len = 16'hFFFF;
      enqueue(w);
      enqueue(make_arp(32'd0, 48'h0123_4567_89AB, STAMP_MAX, OPC_REQUEST, gen_local_ip ^ 1));
      enqueue(make_lookup(32'd0, 32'd299));
      enqueue(make_lookup(32'd0, 32'd300));
      // One broken header field at a time: each packet is dropped without a reply.
      for (i = 0; i < 5; i++) begin
         w = make_arp(32'h0A00_0063, 48'h0200_0000_0001, 32'd5, OPC_REQUEST, gen_local_ip);
         case (i)
            0: w.f.pkt_len = MIN_PKT_LEN - 1;
            1: w.f.hw_type = 16'h0006;
            2: w.f.ptype = 16'h0806;
            3: w.f.hw_len = 8'd0;
            default: w.f.plen = 8'hFF;
         endcase
         enqueue(w);
      end
      // The unused operation code with every field set is answered as dropped.
      w.op = OP_UNUSED;
      w.f = '1;
      enqueue(w);
      // An unknown opcode aimed at us is learned but not answered.
      enqueue(make_arp(32'h0A00_0063, 48'h0200_0000_0001, 32'd5, 16'hFFFF, gen_local_ip));
      enqueue(make_clear());
      enqueue(make_lookup(32'h0A00_0063, 32'd5));

      for (i = 0; i < 480; i++) enqueue_random_word();

      // Second phase: roles swapped, a zero lifetime so only same-second lookups hit,
      // own address zero, and a clock about to wrap.
      start_phase(32'd0, 32'd0, 54, 33);
      gen_now = 32'hFFFF_FF00;
      for (i = 0; i < 500; i++) enqueue_random_word();

      // Third phase: no idling, largest lifetime and own address, and the long
      // receiver hold-off at its start.
      start_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
      hold_off_wanted = 1'b1;
      // Fill every slot with the largest stamp: a new sender then finds no room, yet a
      // request aimed at us is still answered.
      enqueue(make_clear());
      for (i = 0; i < SLOTS; i++)
         enqueue(make_arp(FILL_BASE + i, 48'({$urandom(), $urandom()}), STAMP_MAX,
                          OPC_REPLY, 32'd0));
      enqueue(make_arp(FILL_BASE + SLOTS, 48'({$urandom(), $urandom()}), STAMP_MAX,
                       OPC_REQUEST, gen_local_ip));
      enqueue(make_lookup(FILL_BASE, STAMP_MAX));
      // Re-stamp one slot low; the next new sender replaces exactly that slot.
      enqueue(make_arp(FILL_BASE + 5, 48'({$urandom(), $urandom()}), 32'd7,
                       OPC_REPLY, 32'd0));
      enqueue(make_arp(FILL_BASE + SLOTS + 1, 48'({$urandom(), $urandom()}), STAMP_MAX,
                       OPC_REPLY, 32'd0));
      enqueue(make_lookup(FILL_BASE + 5, STAMP_MAX));
      enqueue(make_lookup(FILL_BASE + SLOTS + 1, STAMP_MAX));
      enqueue(make_clear());
      for (i = 0; i < 120; i++) enqueue_random_word();

      // Last phase: a short lifetime and a random own address, still without idling.
      start_phase($urandom(), 32'd20, 0, 0);
      for (i = 0; i < 500; i++) enqueue_random_word();

      drain();
      repeat (SLOTS + 8) @(negedge clock);
      if (expected_answers.size() != 0) begin
         $display("[%0t] %0d result words never arrived", $time, expected_answers.size());
         failures++;
      end
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: arp_cache_engine.f
design/ace_pkg.sv
design/ace_scan_unit.sv
design/arp_cache_engine.sv
sim/arp_cache_engine_tb.sv
